// File: rtl/core/lkvt_pkg.sv
// Shared types, sizes and command/status codes for the linear key/value table.
`timescale 1ns / 1ps

package lkvt_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BITS    = 64;
  localparam int VALUE_BITS  = 64;

  // Internal index and count widths follow the depth.
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = CNT_W + 1;

  // Fixed port widths.
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int KEY_PORT_W  = 64;
  localparam int VAL_PORT_W  = 64;
  localparam int INDEX_W     = 6;
  localparam int COUNT_W     = 7;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  // Memory access request from the sequencer.
  typedef struct packed {
    logic                  key_we;
    logic                  val_we;
    logic [IDX_W-1:0]      waddr;
    logic [IDX_W-1:0]      raddr;
    logic [KEY_BITS-1:0]   wkey;
    logic [VALUE_BITS-1:0] wval;
  } mem_req_t;

  // One result beat.
  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [IDX_W-1:0]      index;
    logic [VALUE_BITS-1:0] value;
    logic [CNT_W-1:0]      count;
  } res_t;

endpackage

// File: rtl/core/lkvt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
`timescale 1ns / 1ps

module lkvt_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/lkvt_seq.sv
// Command sequencer: scans the key memory, applies the command and shifts on delete.
`timescale 1ns / 1ps

module lkvt_seq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lkvt_pkg::CMD_W-1:0]          cmd_i,
  input  logic [lkvt_pkg::KEY_BITS-1:0]       key_i,
  input  logic [lkvt_pkg::VALUE_BITS-1:0]     value_i,
  input  logic [lkvt_pkg::KEY_BITS-1:0]       key_rdata_i,
  input  logic [lkvt_pkg::VALUE_BITS-1:0]     val_rdata_i,
  output lkvt_pkg::mem_req_t                  mem_o,
  output logic                                res_valid_o,
  output lkvt_pkg::res_t                      res_o,
  input  logic                                res_take_i
);

  localparam int IdxW = lkvt_pkg::IDX_W;
  localparam int CntW = lkvt_pkg::CNT_W;
  localparam int CmpW = lkvt_pkg::CMP_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_ACT    = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]                          state_q, state_d;
  logic [lkvt_pkg::CMD_W-1:0]          cmd_q, cmd_d;
  logic [lkvt_pkg::KEY_BITS-1:0]       key_q, key_d;
  logic [lkvt_pkg::VALUE_BITS-1:0]     val_q, val_d;
  logic [lkvt_pkg::VALUE_BITS-1:0]     hitval_q, hitval_d;
  logic [CntW-1:0]                     count_q, count_d;
  logic [IdxW-1:0]                     ptr_q, ptr_d;
  logic                                hit_q, hit_d;
  logic [lkvt_pkg::STATUS_W-1:0]       status_q, status_d;
  logic [IdxW-1:0]                     index_q, index_d;
  logic [lkvt_pkg::VALUE_BITS-1:0]     rval_q, rval_d;

  logic [CmpW-1:0] ptr_ext;
  logic [CmpW-1:0] cnt_ext;

  assign ptr_ext = CmpW'(ptr_q);
  assign cnt_ext = CmpW'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    val_q    <= val_d;
    hitval_q <= hitval_d;
    ptr_q    <= ptr_d;
    hit_q    <= hit_d;
    status_q <= status_d;
    index_q  <= index_d;
    rval_q   <= rval_d;
  end

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    key_d    = key_q;
    val_d    = val_q;
    hitval_d = hitval_q;
    count_d  = count_q;
    ptr_d    = ptr_q;
    hit_d    = hit_q;
    status_d = status_q;
    index_d  = index_q;
    rval_d   = rval_q;

    mem_o.key_we = 1'b0;
    mem_o.val_we = 1'b0;
    mem_o.waddr  = ptr_q;
    mem_o.raddr  = IdxW'(ptr_ext + CmpW'(1));
    mem_o.wkey   = key_q;
    mem_o.wval   = val_q;

    unique case (state_q)
      S_IDLE: begin
        mem_o.raddr = '0;
        if (in_valid_i) begin
          cmd_d = cmd_i;
          key_d = key_i;
          val_d = value_i;
          ptr_d = '0;
          hit_d = 1'b0;
          // Empty table: nothing to scan.
          state_d = (count_q == '0) ? S_ACT : S_SCAN;
        end
      end

      S_SCAN: begin
        if (key_rdata_i == key_q) begin
          hit_d    = 1'b1;
          hitval_d = val_rdata_i;
          state_d  = S_ACT;
        end else if (ptr_ext + CmpW'(1) == cnt_ext) begin
          hit_d   = 1'b0;
          state_d = S_ACT;
        end else begin
          ptr_d = IdxW'(ptr_ext + CmpW'(1));
        end
      end

      S_ACT: begin
        status_d = lkvt_pkg::ST_DONE;
        index_d  = ptr_q;
        rval_d   = '0;
        state_d  = S_FINISH;
        unique case (cmd_q)
          lkvt_pkg::CMD_INSERT: begin
            if (hit_q) begin
              status_d = lkvt_pkg::ST_PRESENT;
            end else if (cnt_ext == CmpW'(lkvt_pkg::TABLE_DEPTH)) begin
              status_d = lkvt_pkg::ST_FULL;
              index_d  = '0;
            end else begin
              mem_o.key_we = 1'b1;
              mem_o.val_we = 1'b1;
              mem_o.waddr  = IdxW'(count_q);
              index_d      = IdxW'(count_q);
              count_d      = CntW'(cnt_ext + CmpW'(1));
            end
          end
          lkvt_pkg::CMD_UPDATE: begin
            if (!hit_q) begin
              status_d = lkvt_pkg::ST_MISSING;
              index_d  = '0;
            end else begin
              mem_o.val_we = 1'b1;
            end
          end
          lkvt_pkg::CMD_SEARCH: begin
            if (!hit_q) begin
              status_d = lkvt_pkg::ST_MISSING;
              index_d  = '0;
            end else begin
              rval_d = hitval_q;
            end
          end
          lkvt_pkg::CMD_DELETE: begin
            if (!hit_q) begin
              status_d = lkvt_pkg::ST_MISSING;
              index_d  = '0;
            end else if (ptr_ext + CmpW'(1) < cnt_ext) begin
              // Fetch the record after the match; raddr default is ptr+1.
              state_d = S_SHIFT;
            end else begin
              count_d = CntW'(cnt_ext - CmpW'(1));
            end
          end
          default: begin
            status_d = lkvt_pkg::ST_MISSING;
          end
        endcase
      end

      S_SHIFT: begin
        // Move record ptr+1 (read last cycle) down into ptr.
        mem_o.key_we = 1'b1;
        mem_o.val_we = 1'b1;
        mem_o.wkey   = key_rdata_i;
        mem_o.wval   = val_rdata_i;
        if (ptr_ext + CmpW'(2) < cnt_ext) begin
          mem_o.raddr = IdxW'(ptr_ext + CmpW'(2));
          ptr_d       = IdxW'(ptr_ext + CmpW'(1));
        end else begin
          count_d = CntW'(cnt_ext - CmpW'(1));
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_FINISH);

  assign res_o.status = status_q;
  assign res_o.index  = index_q;
  assign res_o.value  = rval_q;
  assign res_o.count  = count_q;

endmodule

// File: rtl/core/linear_key_value_table.sv
// Top level of the linear key/value table: sequencer, key and value memories, output register.
`timescale 1ns / 1ps

// Linear key/value table.
// Input channel (in_valid_i / in_stall_o): one beat carries cmd_i (insert,
// update, delete, search), key_i and value_i. Output channel (out_valid_o /
// out_stall_i): one beat per input beat with status_o, index_o, value_out_o
// and count_o, the record count after the command.
// Records live in two registered-read RAMs (keys, values), searched from
// position 0 one entry per cycle; the first equal key is the match.
// A command passes an accept state, a scan up to the match (at most N
// positions for N stored records), an apply state, the shift of the
// records after the match on delete, and the output register. Scan and
// shift together cover at most N positions.
// One command is in flight at a time; in_stall_o is high while it works.
// The output register lets the next command start while a result waits:
// a stalled result holds, and a finished command waits in its last state
// until the register frees up.
// Reset clears the record count, sequencer state and output valid flag;
// memory contents are not cleared and need no clearing pass, since only
// positions below the count are ever used.

module linear_key_value_table (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [lkvt_pkg::CMD_W-1:0]           cmd_i,
  input  logic [lkvt_pkg::KEY_PORT_W-1:0]      key_i,
  input  logic [lkvt_pkg::VAL_PORT_W-1:0]      value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [lkvt_pkg::STATUS_W-1:0]        status_o,
  output logic [lkvt_pkg::INDEX_W-1:0]         index_o,
  output logic [lkvt_pkg::VAL_PORT_W-1:0]      value_out_o,
  output logic [lkvt_pkg::COUNT_W-1:0]         count_o
);

  lkvt_pkg::mem_req_t                   mem_req;
  logic [lkvt_pkg::KEY_BITS-1:0]        key_rdata;
  logic [lkvt_pkg::VALUE_BITS-1:0]      val_rdata;
  logic                                 res_valid;
  lkvt_pkg::res_t                       res;
  logic                                 res_take;

  logic                                 out_valid_q;
  lkvt_pkg::res_t                       out_q;

  // The output register can take a new result when empty or when its
  // current beat leaves this cycle.
  assign res_take = !out_valid_q || !out_stall_i;

  lkvt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .key_i       (key_i[lkvt_pkg::KEY_BITS-1:0]),
    .value_i     (value_i[lkvt_pkg::VALUE_BITS-1:0]),
    .key_rdata_i (key_rdata),
    .val_rdata_i (val_rdata),
    .mem_o       (mem_req),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  // Key store.
  lkvt_ram #(
    .Width (lkvt_pkg::KEY_BITS),
    .Depth (lkvt_pkg::TABLE_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.key_we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wkey),
    .raddr_i (mem_req.raddr),
    .rdata_o (key_rdata)
  );

  // Value store, addressed in lockstep with the key store.
  lkvt_ram #(
    .Width (lkvt_pkg::VALUE_BITS),
    .Depth (lkvt_pkg::TABLE_DEPTH)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.val_we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wval),
    .raddr_i (mem_req.raddr),
    .rdata_o (val_rdata)
  );

  // Output register: load a finished result, drop the beat once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign index_o     = lkvt_pkg::INDEX_W'(out_q.index);
  assign value_out_o = lkvt_pkg::VAL_PORT_W'(out_q.value);
  assign count_o     = lkvt_pkg::COUNT_W'(out_q.count);

endmodule
